// ===== rtl/core/zsbf_pkg.sv =====
package zsbf_pkg;

	localparam logic [15:0] ADLER_MOD = 16'd65521;

	localparam logic [7:0] ZLIB_CMF     = 8'h78;
	localparam logic [7:0] ZLIB_FLG     = 8'h01;
	localparam logic [7:0] STORED_FINAL = 8'h01;

	// header byte positions
	localparam logic [2:0] HDR_CMF    = 3'd0;
	localparam logic [2:0] HDR_FLG    = 3'd1;
	localparam logic [2:0] HDR_BTYPE  = 3'd2;
	localparam logic [2:0] HDR_LEN_LO = 3'd3;
	localparam logic [2:0] HDR_LEN_HI = 3'd4;
	localparam logic [2:0] HDR_NLEN_LO = 3'd5;
	localparam logic [2:0] HDR_NLEN_HI = 3'd6;

	// trailer byte positions, Adler-32 most significant first
	localparam logic [1:0] TRL_B_HI = 2'd0;
	localparam logic [1:0] TRL_B_LO = 2'd1;
	localparam logic [1:0] TRL_A_HI = 2'd2;
	localparam logic [1:0] TRL_A_LO = 2'd3;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] len;
		logic        last;
	} zsbf_entry_t;

	typedef enum logic [1:0] {
		ST_HDR,
		ST_BODY,
		ST_TRL
	} zsbf_state_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [15:0] len);
		logic [7:0] b;
		case (idx)
			HDR_CMF:     b = ZLIB_CMF;
			HDR_FLG:     b = ZLIB_FLG;
			HDR_BTYPE:   b = STORED_FINAL;
			HDR_LEN_LO:  b = len[7:0];
			HDR_LEN_HI:  b = len[15:8];
			HDR_NLEN_LO: b = ~len[7:0];
			HDR_NLEN_HI: b = ~len[15:8];
			default:     b = 8'h00;
		endcase
		return b;
	endfunction

	// both operands below ADLER_MOD, so one conditional subtract suffices
	function automatic logic [15:0] mod_add(input logic [15:0] x, input logic [15:0] y);
		logic [16:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, ADLER_MOD}) begin
			s = s - {1'b0, ADLER_MOD};
		end
		return s[15:0];
	endfunction

endpackage

// ===== rtl/core/zsbf_front.sv =====
module zsbf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic [15:0]        block_length,
	output logic               q_push,
	output zsbf_pkg::zsbf_entry_t q_entry
);
	import zsbf_pkg::*;

	logic        in_frame_q;
	logic [15:0] left_q;
	logic [15:0] left_now;

	// a fresh frame takes its count from the beat itself
	assign left_now = in_frame_q ? left_q : block_length;

	always_comb begin
		q_entry.data  = data_byte;
		q_entry.len   = block_length;
		q_entry.last  = (left_now == 16'd1);
		q_push        = accept && (left_now != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= 16'd0;
		end else if (q_push) begin
			left_q     <= left_now - 16'd1;
			in_frame_q <= (left_now != 16'd1);
		end
	end

endmodule

// ===== rtl/core/zsbf_fifo.sv =====
module zsbf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  zsbf_pkg::zsbf_entry_t  push_entry,
	input  logic                   pop,
	output zsbf_pkg::zsbf_entry_t  head,
	output logic                   head_valid,
	output logic                   full
);
	import zsbf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	zsbf_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/zsbf_back.sv =====
module zsbf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  zsbf_pkg::zsbf_entry_t head,
	input  logic                  head_valid,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [7:0]            out_byte,
	output logic                  end_of_frame
);
	import zsbf_pkg::*;

	zsbf_state_t st_q, st_d;
	logic [2:0]  idx_q, idx_d;
	logic [15:0] sum_a_q;
	logic [15:0] sum_b_q;
	logic        b_pend_q;
	logic [7:0]  byte_q;
	logic        eof_q;
	logic        valid_q;

	logic        room;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_eof;
	logic        data_step;
	logic        frame_start;

	assign room         = !valid_q || pop;
	assign empty        = !valid_q;
	assign out_byte     = byte_q;
	assign end_of_frame = eof_q;

	always_comb begin
		emit        = 1'b0;
		emit_byte   = 8'h00;
		emit_eof    = 1'b0;
		q_pop       = 1'b0;
		data_step   = 1'b0;
		frame_start = 1'b0;
		unique case (st_q)
			ST_HDR: begin
				if (head_valid && room) begin
					emit        = 1'b1;
					emit_byte   = hdr_byte(idx_q, head.len);
					frame_start = (idx_q == HDR_CMF);
				end
			end
			ST_BODY: begin
				if (head_valid && room) begin
					emit      = 1'b1;
					emit_byte = head.data;
					q_pop     = 1'b1;
					data_step = 1'b1;
				end
			end
			ST_TRL: begin
				// sum B is updated in the cycle after the last data beat
				if (!b_pend_q && room) begin
					emit = 1'b1;
					unique case (idx_q[1:0])
						TRL_B_HI: emit_byte = sum_b_q[15:8];
						TRL_B_LO: emit_byte = sum_b_q[7:0];
						TRL_A_HI: emit_byte = sum_a_q[15:8];
						TRL_A_LO: emit_byte = sum_a_q[7:0];
					endcase
					emit_eof = (idx_q[1:0] == TRL_A_LO);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		unique case (st_q)
			ST_HDR: begin
				if (emit) begin
					if (idx_q == HDR_NLEN_HI) begin
						st_d  = ST_BODY;
						idx_d = 3'd0;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			ST_BODY: begin
				if (emit && head.last) begin
					st_d  = ST_TRL;
					idx_d = 3'd0;
				end
			end
			ST_TRL: begin
				if (emit) begin
					if (idx_q[1:0] == TRL_A_LO) begin
						st_d  = ST_HDR;
						idx_d = 3'd0;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				st_d  = ST_HDR;
				idx_d = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_HDR;
			idx_q    <= 3'd0;
			valid_q  <= 1'b0;
			b_pend_q <= 1'b0;
			sum_a_q  <= 16'd1;
			sum_b_q  <= 16'd0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			b_pend_q <= data_step;
			if (frame_start) begin
				sum_a_q <= 16'd1;
				sum_b_q <= 16'd0;
			end else begin
				if (data_step) begin
					sum_a_q <= mod_add(sum_a_q, {8'h00, head.data});
				end
				if (b_pend_q) begin
					sum_b_q <= mod_add(sum_b_q, sum_a_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			eof_q  <= emit_eof;
		end
	end

endmodule

// ===== rtl/core/zlib_stored_block_framer.sv =====
// zlib stored-block framer.
// Input queue: data_byte with block_length, written by push while full is low.
// block_length is only looked at on the first beat of a frame; a first beat
// with length zero is dropped. Output queue: out_byte and end_of_frame are
// the oldest byte while empty is low; pop takes it.
// Each frame comes out as 78 01, the stored-block byte 01, LEN, NLEN (low
// byte first), the data bytes, then the Adler-32 value most significant byte
// first, end_of_frame marking its last byte.
// Throughput: one data byte per cycle in the body of a frame while the
// receiver pops each byte. The first beat costs 7 header bytes plus the data
// byte, the last beat the data byte and 4 trailer bytes, and the trailer
// waits while the high Adler sum settles; the output register, one byte per
// cycle, sets the pace. A beat's first output byte passes the queue and then
// the output register before it reaches the ports.
// A FIFO_DEPTH entry queue sits between the input classifier and the byte
// emitter, so input keeps flowing while the emitter sends header or trailer.
// When the receiver stalls, the output byte holds, the queue fills and full
// rises. Reset empties both queues and leaves the block between frames.
module zlib_stored_block_framer #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [15:0] block_length,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        end_of_frame
);
	import zsbf_pkg::*;

	zsbf_entry_t push_entry;
	zsbf_entry_t head;
	logic        q_push;
	logic        q_pop;
	logic        head_valid;

	zsbf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (push && !full),
		.data_byte    (data_byte),
		.block_length (block_length),
		.q_push       (q_push),
		.q_entry      (push_entry)
	);

	zsbf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	zsbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame)
	);

endmodule

// ===== rtl/core/zsbf_checker.sv =====
module zsbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  data_byte,
	input logic [15:0] block_length,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  out_byte,
	input logic        end_of_frame
);
	import zsbf_pkg::*;

	logic frame_next_q;
	logic seen_push_q;

	// next output beat opens a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_next_q <= 1'b1;
			seen_push_q  <= 1'b0;
		end else begin
			if (pop && !empty) begin
				frame_next_q <= end_of_frame;
			end
			if (push && !full && (block_length != 16'd0 || data_byte != data_byte)) begin
				seen_push_q <= 1'b1;
			end
		end
	end

	a_frame_opens_with_cmf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_next_q) |-> (out_byte == ZLIB_CMF && !end_of_frame))
		else $error("frame does not open with the zlib header");

	a_no_output_unprompted: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_push_q |-> empty)
		else $error("output beat before any accepted frame");

	a_eof_not_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && end_of_frame) |=> (empty || !end_of_frame))
		else $error("two end-of-frame beats in a row");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_frame)))
		else $error("stalled output beat changed");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (.*);
